>>> sv/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

  // Pool geometry; ALIGN_BYTES must be a power of two.
  localparam int MAX_BLOCKS  = 256;
  localparam int ALIGN_BYTES = 16;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);

  // Field widths fixed by the interface.
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 9;

  // Derived widths.
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int DEPTH_W    = $clog2(MAX_BLOCKS + 1);
  localparam int UNIT_W     = $clog2(((1 << SIZE_W) - 1 + ALIGN_BYTES - 1) / ALIGN_BYTES + 1);
  localparam int DVD_W      = ADDR_W - ALIGN_SHIFT;
  localparam int PROD_W     = IDX_W + UNIT_W;
  localparam int MUL_CNT_W  = $clog2(IDX_W + 1);
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  // Register reset values.
  localparam int RST_SIZE  = 16;
  localparam int RST_COUNT = 256;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic             done;
    logic             rem_zero;
    logic [DVD_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

>>> sv/fixed_block_pool_allocator_core.sv
// Sequencing: an allocate runs the multiplier (after popping a freed block through the
//   pop and load states), a free or check runs the divider; a failed allocate or the
//   unused code goes straight to the result state, which loads the output register.
// One item at a time: the next is accepted only after the result is loaded, and is held
//   off while the output stalls; the 28-step divider and the 8-step multiplier set the pace.
// Reset: synchronous; registers return to base 0, size 16, count 256, pool empty of use.
`default_nettype none

module fixed_block_pool_allocator_core
  import fbpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Operation items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [ADDR_W-1:0] address,
  // Result items
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   ok,
  output logic      [ADDR_W-1:0] block_address,
  output logic      [CNT_W-1:0]  blocks_in_use,
  // Configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  // Configuration registers
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] requested_block_size;
  logic [CNT_W-1:0]  block_count;

  // Pool state
  logic [DEPTH_W-1:0] freed_depth;
  logic [DEPTH_W-1:0] untouched_remaining;
  logic [CNT_W-1:0]   used_count;

  // Item in flight
  state_t            state;
  state_t            state_next;
  logic [1:0]        op;
  logic              low_ok;
  logic              res_ok;
  logic [ADDR_W-1:0] res_addr;

  // Derived pool geometry
  logic [SIZE_W-1:0]  size_req;
  logic [SIZE_W:0]    units_wide;
  logic [UNIT_W-1:0]  size_units;
  logic [DEPTH_W-1:0] eff_count;
  logic [CNT_W-1:0]   count_written;
  logic [DEPTH_W-1:0] count_reinit;

  // Control strobes
  logic              in_accept;
  logic              cfg_we;
  logic              mul_start;
  logic [IDX_W-1:0]  mul_mplier;
  logic              div_start;
  logic              rd_en;
  logic              wr_en;
  logic              load_out;
  logic              hit;
  logic [ADDR_W-1:0] off_in;
  logic [IDX_W-1:0]  rd_data;

  mul_res_t mul_res;
  div_res_t div_res;

  // A zero request counts as one byte, then round up to whole alignment units.
  assign size_req   = (requested_block_size == '0) ? SIZE_W'(1) : requested_block_size;
  assign units_wide = ((SIZE_W + 1)'(size_req) + (SIZE_W + 1)'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT;
  assign size_units = UNIT_W'(units_wide);

  assign eff_count = (int'(block_count) > MAX_BLOCKS) ? DEPTH_W'(MAX_BLOCKS)
                                                      : DEPTH_W'(block_count);

  // Reinit uses the count as it stands after this write.
  assign count_written = (cfg_index == REG_COUNT) ? cfg_data[CNT_W-1:0] : block_count;
  assign count_reinit  = (int'(count_written) > MAX_BLOCKS) ? DEPTH_W'(MAX_BLOCKS)
                                                            : DEPTH_W'(count_written);

  // Offset into the region wraps mod 2^32; work in alignment units from here on.
  assign off_in = address - base_address;

  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Valid block: aligned, whole multiple of the block size, index below the count.
  assign hit = low_ok && div_res.rem_zero && (div_res.quot < DVD_W'(eff_count));

  // Push a freed index unless the stack is full.
  assign wr_en = (state == ST_DIV) && div_res.done && (op == OP_FREE) && hit
                 && (int'(freed_depth) < MAX_BLOCKS);

  fbpa_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (freed_depth[IDX_W-1:0]),
    .wr_data (div_res.quot[IDX_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (IDX_W'(freed_depth - 1'b1)),
    .rd_data (rd_data)
  );

  fbpa_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mplier (mul_mplier),
    .mcand  (size_units),
    .res    (mul_res)
  );

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off_in[ADDR_W-1:ALIGN_SHIFT]),
    .divisor  (size_units),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_mplier = rd_data;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (operation)
            OP_ALLOC: begin
              // Freed blocks go first, then untouched ones from the top index down.
              if (freed_depth != '0) begin
                state_next = ST_POP;
              end else if (untouched_remaining != '0) begin
                mul_start  = 1'b1;
                mul_mplier = IDX_W'(untouched_remaining - 1'b1);
                state_next = ST_MUL;
              end else begin
                state_next = ST_RESULT;
              end
            end
            OP_FREE, OP_CHECK: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_POP: begin
        rd_en      = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_res.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // Hold until the output register is free or being drained.
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address         <= '0;
      requested_block_size <= SIZE_W'(RST_SIZE);
      block_count          <= CNT_W'(RST_COUNT);
      freed_depth          <= '0;
      untouched_remaining  <= (RST_COUNT > MAX_BLOCKS) ? DEPTH_W'(MAX_BLOCKS)
                                                       : DEPTH_W'(RST_COUNT);
      used_count           <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE: begin
            base_address <= cfg_data;
          end
          REG_SIZE: begin
            requested_block_size <= cfg_data[SIZE_W-1:0];
          end
          REG_COUNT: begin
            block_count <= cfg_data[CNT_W-1:0];
          end
          default: begin
          end
        endcase
        // Any write to a defined register reinitializes the pool.
        if (cfg_index == REG_BASE || cfg_index == REG_SIZE || cfg_index == REG_COUNT) begin
          freed_depth         <= '0;
          untouched_remaining <= count_reinit;
          used_count          <= '0;
        end
      end

      if (in_accept && operation == OP_ALLOC && freed_depth == '0
          && untouched_remaining != '0) begin
        untouched_remaining <= untouched_remaining - 1'b1;
      end

      if (rd_en) begin
        freed_depth <= freed_depth - 1'b1;
      end

      if (state == ST_MUL && mul_res.done && used_count != '1) begin
        used_count <= used_count + 1'b1;
      end

      if (state == ST_DIV && div_res.done && op == OP_FREE && hit) begin
        if (wr_en) begin
          freed_depth <= freed_depth + 1'b1;
        end
        if (used_count != '0) begin
          used_count <= used_count - 1'b1;
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload and result registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op       <= operation;
      low_ok   <= ((off_in & ADDR_W'(ALIGN_BYTES - 1)) == '0);
      res_ok   <= 1'b0;
      res_addr <= '0;
    end
    if (state == ST_MUL && mul_res.done) begin
      res_ok   <= 1'b1;
      res_addr <= base_address + (ADDR_W'(mul_res.prod) << ALIGN_SHIFT);
    end
    if (state == ST_DIV && div_res.done) begin
      res_ok <= hit;
    end
    if (load_out) begin
      ok            <= res_ok;
      block_address <= res_addr;
      blocks_in_use <= used_count;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(freed_depth) <= MAX_BLOCKS)
    else $error("freed stack depth past capacity");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("item accepted without leaving idle");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_res.done |-> state == ST_MUL)
    else $error("multiplier finished outside its wait state");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESULT)
    else $error("result shown without passing the result state");

endmodule

`default_nettype wire

>>> sv/fbpa_stack.sv
`default_nettype none

module fbpa_stack
  import fbpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [IDX_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/fbpa_mul.sv
`default_nettype none

// Serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module fbpa_mul
  import fbpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [IDX_W-1:0]  mplier,
  input  wire logic [UNIT_W-1:0] mcand,
  output mul_res_t               res
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [IDX_W-1:0]     mpl;
  logic [UNIT_W-1:0]    mcd;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    acc_next;
  logic                 last;

  assign last     = (cnt == MUL_CNT_W'(IDX_W - 1));
  assign acc_next = {acc[PROD_W-2:0], 1'b0} + (mpl[IDX_W-1] ? PROD_W'(mcd) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      mpl <= mplier;
      mcd <= mcand;
      acc <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      mpl <= {mpl[IDX_W-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign res.done = done;
  assign res.prod = acc;

endmodule

`default_nettype wire

>>> sv/fbpa_div.sv
`default_nettype none

// Restoring long division, one dividend bit per cycle.
module fbpa_div
  import fbpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [UNIT_W-1:0] divisor,
  output div_res_t               res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [UNIT_W-1:0]    rem;
  logic [UNIT_W-1:0]    dvs;
  logic [DVD_W-1:0]     shreg;
  logic [UNIT_W:0]      trial;
  logic [UNIT_W:0]      diff;
  logic                 ge;
  logic                 last;

  assign last  = (cnt == DIV_CNT_W'(DVD_W - 1));
  assign trial = {rem, shreg[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift dividend bits out the top, quotient bits in the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= '0;
      rem   <= '0;
      dvs   <= divisor;
      shreg <= dividend;
    end else if (busy) begin
      cnt   <= cnt + 1'b1;
      rem   <= ge ? diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
      shreg <= {shreg[DVD_W-2:0], ge};
    end
  end

  assign res.done     = done;
  assign res.rem_zero = (rem == '0);
  assign res.quot     = shreg;

endmodule

`default_nettype wire
